>>> rtl/core/bnfa_pkg.sv
// shared types, codes and helpers for the next-fit bitmap allocator
// no dependencies; imported by every module of the block

package bnfa_pkg;

    localparam int unsigned ENTRIES     = 256;
    localparam int unsigned IDX_W       = 8;
    localparam int unsigned SLICE_W     = 32;
    localparam int unsigned SLICES      = ENTRIES / SLICE_W;
    localparam int unsigned SLICE_SEL_W = 3;
    localparam int unsigned BIT_W       = 5;
    localparam int unsigned COUNT_W     = 9;

    // request modes
    localparam logic [1:0] MODE_ALLOC   = 2'd0;
    localparam logic [1:0] MODE_RELEASE = 2'd1;
    localparam logic [1:0] MODE_TEST    = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    localparam logic [IDX_W-1:0] CURSOR_RESET = 8'd2;

    typedef struct packed {
        logic capture;
        logic exec;
        logic step;
        logic load;
    } bnfa_cmd_t;

    typedef struct packed {
        logic done;
        logic out_free;
    } bnfa_stat_t;

    typedef struct packed {
        logic             hit;
        logic [BIT_W-1:0] pos;
    } find_t;

    // lowest set bit of one slice
    function automatic find_t find_first(input logic [SLICE_W-1:0] bits);
        find_t f;
        f = '0;
        for (int i = SLICE_W - 1; i >= 0; i--)
        begin
            if (bits[i])
            begin
                f.hit = 1'b1;
                f.pos = BIT_W'(i);
            end
        end
        return f;
    endfunction

endpackage

>>> rtl/core/bnfa_ctrl.sv
// sequencer for the next-fit bitmap allocator
// depends on bnfa_pkg; drives commands into bnfa_datapath

module bnfa_ctrl
    import bnfa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_stall,
    input  bnfa_stat_t stat,
    output bnfa_cmd_t  cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_DONE
    } state_t;

    state_t state_reg;
    logic   stall_reg;

    assign req_stall = stall_reg;

    always_comb
    begin
        cmd.capture = (state_reg == S_IDLE) && req_valid;
        cmd.exec    = (state_reg == S_EXEC);
        cmd.step    = (state_reg == S_SCAN);
        cmd.load    = (state_reg == S_DONE) && stat.out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            stall_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        state_reg <= S_EXEC;
                        stall_reg <= 1'b1;
                    end
                end
                S_EXEC:
                begin
                    state_reg <= stat.done ? S_DONE : S_SCAN;
                end
                S_SCAN:
                begin
                    if (stat.done)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    // result moves out here; the next word is taken in the following cycle, from S_IDLE
                    if (stat.out_free)
                    begin
                        state_reg <= S_IDLE;
                        stall_reg <= 1'b0;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                    stall_reg <= 1'b0;
                end
            endcase
        end
    end

endmodule

>>> rtl/core/bnfa_datapath.sv
// free map, cursor, used count, slice scan and output register
// depends on bnfa_pkg; sequenced by bnfa_ctrl

module bnfa_datapath
    import bnfa_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  bnfa_cmd_t          cmd,
    output bnfa_stat_t         stat,
    input  logic [1:0]         mode,
    input  logic [8:0]         entry_index,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output logic [1:0]         status,
    output logic [IDX_W-1:0]   granted_index,
    output logic               is_assigned,
    output logic [COUNT_W-1:0] used_count
);

    logic [1:0]             mode_reg;
    logic [8:0]             idx_reg;
    logic [SLICE_W-1:0]     map_reg [SLICES];
    logic [IDX_W-1:0]       cursor_reg, cursor_next;
    logic [COUNT_W-1:0]     count_reg, count_next;
    logic [SLICE_SEL_W-1:0] row_reg, row_next;
    logic [SLICE_SEL_W-1:0] steps_reg, steps_next;
    find_t                  low_reg, low_next;
    logic [SLICE_W-1:0]     low_word_reg, low_word_next;
    logic [1:0]             res_status_reg, res_status_next;
    logic [IDX_W-1:0]       res_grant_reg, res_grant_next;
    logic                   res_asg_reg, res_asg_next;
    logic                   out_valid_reg, out_valid_next;
    logic [1:0]             out_status_reg;
    logic [IDX_W-1:0]       out_grant_reg;
    logic                   out_asg_reg;
    logic [COUNT_W-1:0]     out_count_reg;

    logic [SLICE_SEL_W-1:0] start_row;
    logic [BIT_W-1:0]       start_bit;
    logic [SLICE_SEL_W-1:0] rd_row;
    logic [SLICE_W-1:0]     rd_data;
    logic [SLICE_W-1:0]     high_mask;
    find_t                  high_find, low_find, full_find;
    logic                   idx_free;
    logic                   wr_en;
    logic [SLICE_SEL_W-1:0] wr_row;
    logic [SLICE_W-1:0]     wr_data;
    logic                   done;

    localparam logic [SLICE_W-1:0] ONE_HOT0 = {{(SLICE_W-1){1'b0}}, 1'b1};

    assign start_row = cursor_reg[IDX_W-1:BIT_W];
    assign start_bit = cursor_reg[BIT_W-1:0];
    assign rd_row    = cmd.exec ? ((mode_reg == MODE_ALLOC) ? start_row
                                                            : idx_reg[IDX_W-1:BIT_W])
                                : row_reg;
    assign rd_data   = map_reg[rd_row];
    assign high_mask = {SLICE_W{1'b1}} << start_bit;
    assign high_find = find_first(rd_data & high_mask);
    assign low_find  = find_first(rd_data & ~high_mask);
    assign full_find = find_first(rd_data);
    assign idx_free  = rd_data[idx_reg[BIT_W-1:0]];

    always_comb
    begin
        cursor_next     = cursor_reg;
        count_next      = count_reg;
        row_next        = row_reg;
        steps_next      = steps_reg;
        low_next        = low_reg;
        low_word_next   = low_word_reg;
        res_status_next = res_status_reg;
        res_grant_next  = res_grant_reg;
        res_asg_next    = res_asg_reg;
        wr_en           = 1'b0;
        wr_row          = rd_row;
        wr_data         = rd_data;
        done            = 1'b0;

        if (cmd.exec)
        begin
            unique case (mode_reg)
                MODE_ALLOC:
                begin
                    // keep the part of the start slice below the cursor for the wrap
                    low_next      = low_find;
                    low_word_next = rd_data & ~(ONE_HOT0 << low_find.pos);
                    if (high_find.hit)
                    begin
                        done            = 1'b1;
                        wr_en           = 1'b1;
                        wr_data         = rd_data & ~(ONE_HOT0 << high_find.pos);
                        cursor_next     = {start_row, high_find.pos} + 8'd1;
                        count_next      = count_reg + 9'd1;
                        res_status_next = ST_OK;
                        res_grant_next  = {start_row, high_find.pos};
                        res_asg_next    = 1'b0;
                    end
                    else
                    begin
                        row_next   = start_row + 3'd1;
                        steps_next = 3'd1;
                    end
                end
                MODE_RELEASE:
                begin
                    done           = 1'b1;
                    res_grant_next = '0;
                    res_asg_next   = 1'b0;
                    if (idx_reg[8])
                    begin
                        res_status_next = ST_RANGE;
                    end
                    else
                    begin
                        res_status_next = ST_OK;
                        if (!idx_free)
                        begin
                            wr_en   = 1'b1;
                            wr_data = rd_data | (ONE_HOT0 << idx_reg[BIT_W-1:0]);
                            if (count_reg != '0)
                            begin
                                count_next = count_reg - 9'd1;
                            end
                        end
                    end
                end
                MODE_TEST:
                begin
                    done           = 1'b1;
                    res_grant_next = '0;
                    if (idx_reg[8] || (idx_reg[IDX_W-1:0] == '0))
                    begin
                        res_status_next = ST_RANGE;
                        res_asg_next    = 1'b0;
                    end
                    else
                    begin
                        res_status_next = ST_OK;
                        res_asg_next    = ~idx_free;
                    end
                end
                default:
                begin
                    done            = 1'b1;
                    res_status_next = ST_RANGE;
                    res_grant_next  = '0;
                    res_asg_next    = 1'b0;
                end
            endcase
        end
        else if (cmd.step)
        begin
            priority if (full_find.hit)
            begin
                done            = 1'b1;
                wr_en           = 1'b1;
                wr_data         = rd_data & ~(ONE_HOT0 << full_find.pos);
                cursor_next     = {row_reg, full_find.pos} + 8'd1;
                count_next      = count_reg + 9'd1;
                res_status_next = ST_OK;
                res_grant_next  = {row_reg, full_find.pos};
                res_asg_next    = 1'b0;
            end
            else if (steps_reg == SLICE_SEL_W'(SLICES - 1))
            begin
                done         = 1'b1;
                res_asg_next = 1'b0;
                if (low_reg.hit)
                begin
                    wr_en           = 1'b1;
                    wr_row          = start_row;
                    wr_data         = low_word_reg;
                    cursor_next     = {start_row, low_reg.pos} + 8'd1;
                    count_next      = count_reg + 9'd1;
                    res_status_next = ST_OK;
                    res_grant_next  = {start_row, low_reg.pos};
                end
                else
                begin
                    res_status_next = ST_FULL;
                    res_grant_next  = '0;
                end
            end
            else
            begin
                row_next   = row_reg + 3'd1;
                steps_next = steps_reg + 3'd1;
            end
        end
    end

    assign stat.done     = done;
    assign stat.out_free = !out_valid_reg || !rsp_stall;

    always_comb
    begin
        if (cmd.load)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && rsp_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < SLICES; r++)
            begin
                map_reg[r] <= '1;
            end
            cursor_reg    <= CURSOR_RESET;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            for (int r = 0; r < SLICES; r++)
            begin
                if (wr_en && (wr_row == SLICE_SEL_W'(r)))
                begin
                    map_reg[r] <= wr_data;
                end
            end
            cursor_reg    <= cursor_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg <= mode;
            idx_reg  <= entry_index;
        end
        row_reg        <= row_next;
        steps_reg      <= steps_next;
        low_reg        <= low_next;
        low_word_reg   <= low_word_next;
        res_status_reg <= res_status_next;
        res_grant_reg  <= res_grant_next;
        res_asg_reg    <= res_asg_next;
        if (cmd.load)
        begin
            out_status_reg <= res_status_reg;
            out_grant_reg  <= res_grant_reg;
            out_asg_reg    <= res_asg_reg;
            out_count_reg  <= count_reg;
        end
    end

    assign rsp_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign granted_index = out_grant_reg;
    assign is_assigned   = out_asg_reg;
    assign used_count    = out_count_reg;

endmodule

>>> rtl/core/bitmap_next_fit_allocator_top.sv
// Next-fit allocator over 256 entries. A word asks to allocate, release or test an
// entry and gives back one result word. Release, test and unused modes finish in
// S_EXEC; allocate scans the free map one 32-bit slice per cycle from the cursor,
// the start slice in S_EXEC and each further slice in S_SCAN. The part of the start
// slice below the cursor is captured in S_EXEC and only used once the other seven
// slices have missed. Each result goes through a result register into the output
// register; the next word is accepted in the cycle after its predecessor's result
// enters the output register, so only one word is in flight at a time.
// depends on bnfa_pkg, bnfa_ctrl and bnfa_datapath

module bitmap_next_fit_allocator_top
    import bnfa_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  logic [1:0]         mode,
    input  logic [8:0]         entry_index,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output logic [1:0]         status,
    output logic [IDX_W-1:0]   granted_index,
    output logic               is_assigned,
    output logic [COUNT_W-1:0] used_count
);

    bnfa_cmd_t  cmd;
    bnfa_stat_t stat;

    bnfa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    bnfa_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .mode          (mode),
        .entry_index   (entry_index),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .status        (status),
        .granted_index (granted_index),
        .is_assigned   (is_assigned),
        .used_count    (used_count)
    );

endmodule

>>> rtl/core/bnfa_checker.sv
// port-level checks for the next-fit allocator, bound to the top level
// depends on bnfa_pkg and bitmap_next_fit_allocator_top

module bnfa_checker
    import bnfa_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_stall,
    input logic               rsp_valid,
    input logic               rsp_stall,
    input logic [1:0]         status,
    input logic [IDX_W-1:0]   granted_index,
    input logic               is_assigned,
    input logic [COUNT_W-1:0] used_count
);

    // a stalled result word holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(status)
            && $stable(granted_index) && $stable(is_assigned) && $stable(used_count))
        else $error("result word changed while stalled");

    // one word at a time: busy right after an accept
    a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("second word accepted while busy");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> used_count <= 9'(ENTRIES))
        else $error("used count beyond map size");

    // full only when every entry is taken
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == ST_FULL |-> used_count == 9'(ENTRIES) && granted_index == '0)
        else $error("full reported with entries left");

    a_assigned_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && is_assigned |-> status == ST_OK && granted_index == '0)
        else $error("assigned flag on a failed or allocate result");

endmodule

bind bitmap_next_fit_allocator_top bnfa_checker u_bnfa_checker (.*);

>>> tb/testbench.sv
// self-checking testbench for the next-fit bitmap allocator: directed table, then
// random fill, drain and mixed traffic, each result word checked against a fixed expectation or a predictor
// depends on bnfa_pkg and bitmap_next_fit_allocator_top

module testbench
    import bnfa_pkg::*;
();

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int RANDOM_WORDS = 1150;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int TAIL_CYCLES  = 12;

    typedef struct packed {
        logic [1:0]         status;
        logic [IDX_W-1:0]   granted;
        logic               assigned;
        logic [COUNT_W-1:0] used;
    } alloc_result_t;

    typedef struct packed {
        logic [1:0]    req_mode;
        logic [8:0]    req_index;
        logic          fixed;
        alloc_result_t want;
    } stim_row_t;

    typedef enum {PH_FILL, PH_DRAIN, PH_MIX} load_phase_t;

    logic               clk;
    logic               rst_n;
    logic               req_valid;
    logic               req_stall;
    logic [1:0]         mode;
    logic [8:0]         entry_index;
    logic               rsp_valid;
    logic               rsp_stall;
    logic [1:0]         status;
    logic [IDX_W-1:0]   granted_index;
    logic               is_assigned;
    logic [COUNT_W-1:0] used_count;

    // predictor state
    logic [ENTRIES-1:0] map_free;
    logic [IDX_W-1:0]   cursor;
    logic [COUNT_W-1:0] taken_entries;

    alloc_result_t awaited_results[$];
    int  errors;
    int  words_sent;
    int  grants;
    int  full_refusals;
    int  range_refusals;
    bit  calm;

    // rows with a fixed result can be read straight off the reset state
    stim_row_t directed_rows [22] = '{
        '{MODE_TEST,    9'd2,   1'b1, '{ST_OK,    8'd0, 1'b0, 9'd0}},
        '{MODE_ALLOC,   9'd0,   1'b1, '{ST_OK,    8'd2, 1'b0, 9'd1}},
        '{MODE_ALLOC,   9'd511, 1'b1, '{ST_OK,    8'd3, 1'b0, 9'd2}},
        '{MODE_TEST,    9'd2,   1'b1, '{ST_OK,    8'd0, 1'b1, 9'd2}},
        '{MODE_TEST,    9'd0,   1'b1, '{ST_RANGE, 8'd0, 1'b0, 9'd2}},
        '{MODE_TEST,    9'd256, 1'b1, '{ST_RANGE, 8'd0, 1'b0, 9'd2}},
        '{MODE_TEST,    9'd511, 1'b1, '{ST_RANGE, 8'd0, 1'b0, 9'd2}},
        '{MODE_RELEASE, 9'd511, 1'b1, '{ST_RANGE, 8'd0, 1'b0, 9'd2}},
        '{MODE_RELEASE, 9'd256, 1'b1, '{ST_RANGE, 8'd0, 1'b0, 9'd2}},
        '{MODE_RELEASE, 9'd0,   1'b1, '{ST_OK,    8'd0, 1'b0, 9'd2}},
        '{MODE_RELEASE, 9'd3,   1'b1, '{ST_OK,    8'd0, 1'b0, 9'd1}},
        '{MODE_RELEASE, 9'd3,   1'b1, '{ST_OK,    8'd0, 1'b0, 9'd1}},
        '{MODE_UNUSED,  9'd0,   1'b1, '{ST_RANGE, 8'd0, 1'b0, 9'd1}},
        '{MODE_UNUSED,  9'd511, 1'b1, '{ST_RANGE, 8'd0, 1'b0, 9'd1}},
        '{MODE_TEST,    9'd255, 1'b1, '{ST_OK,    8'd0, 1'b0, 9'd1}},
        '{MODE_TEST,    9'd3,   1'b1, '{ST_OK,    8'd0, 1'b0, 9'd1}},
        '{MODE_ALLOC,   9'd0,   1'b1, '{ST_OK,    8'd4, 1'b0, 9'd2}},
        '{MODE_RELEASE, 9'd2,   1'b1, '{ST_OK,    8'd0, 1'b0, 9'd1}},
        '{MODE_ALLOC,   9'd0,   1'b0, '0},
        '{MODE_RELEASE, 9'd255, 1'b0, '0},
        '{MODE_TEST,    9'd170, 1'b0, '0},
        '{MODE_TEST,    9'd85,  1'b0, '0}
    };

    bitmap_next_fit_allocator_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .mode          (mode),
        .entry_index   (entry_index),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .status        (status),
        .granted_index (granted_index),
        .is_assigned   (is_assigned),
        .used_count    (used_count)
    );

    always #5 clk = ~clk;

    task automatic flag_error(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        errors++;
    endtask

    function automatic int draw_wait();
        return calm ? 0 : int'($urandom_range(0, 19));
    endfunction

    // next-fit allocation over the predictor's own map, cursor and count
    function automatic alloc_result_t serve_request(input logic [1:0] m,
                                                     input logic [8:0] idx);
        alloc_result_t r;
        int pos;
        bit found;
        r = '0;
        found = 1'b0;
        case (m)
            MODE_ALLOC:
            begin
                for (int off = 0; off < ENTRIES; off++)
                begin
                    pos = (int'(cursor) + off) % ENTRIES;
                    if (!found && map_free[pos])
                    begin
                        found = 1'b1;
                        map_free[pos] = 1'b0;
                        taken_entries++;
                        cursor = IDX_W'((pos + 1) % ENTRIES);
                        r.granted = IDX_W'(pos);
                    end
                end
                r.status = found ? ST_OK : ST_FULL;
            end
            MODE_RELEASE:
            begin
                if (idx >= ENTRIES)
                    r.status = ST_RANGE;
                else
                begin
                    // a release of a free entry leaves the count alone
                    if (!map_free[idx])
                    begin
                        map_free[idx] = 1'b1;
                        if (taken_entries > 0)
                            taken_entries--;
                    end
                    r.status = ST_OK;
                end
            end
            MODE_TEST:
            begin
                if (idx == 0 || idx >= ENTRIES)
                    r.status = ST_RANGE;
                else
                begin
                    r.status = ST_OK;
                    r.assigned = ~map_free[idx];
                end
            end
            default:
                r.status = ST_RANGE;
        endcase
        r.used = taken_entries;
        return r;
    endfunction

    // mostly aim releases at entries that are really taken
    function automatic logic [8:0] pick_taken();
        logic [8:0] idx;
        idx = 9'($urandom_range(0, ENTRIES - 1));
        for (int i = 0; i < 6; i++)
        begin
            if (map_free[idx])
                idx = 9'($urandom_range(0, ENTRIES - 1));
        end
        return idx;
    endfunction

    task automatic send_word(input logic [1:0] m, input logic [8:0] idx, input logic fixed,
                             input alloc_result_t want);
        int gap;
        alloc_result_t predicted;
        gap = draw_wait();
        repeat (gap)
        begin
            @(negedge clk);
            req_valid <= 1'b0;
        end
        @(negedge clk);
        req_valid   <= 1'b1;
        mode        <= m;
        entry_index <= idx;
        do
            @(posedge clk);
        while (req_stall !== 1'b0);
        predicted = serve_request(m, idx);
        awaited_results.push_back(fixed ? want : predicted);
        words_sent++;
        if (m == MODE_ALLOC && predicted.status == ST_OK)
            grants++;
        if (predicted.status == ST_FULL)
            full_refusals++;
        if (predicted.status == ST_RANGE)
            range_refusals++;
    endtask

    task automatic hold_until_drained();
        @(negedge clk);
        req_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
    endtask

    // result side: random stalls, then take one word and check it
    initial
    begin
        int stall_len;
        alloc_result_t got;
        alloc_result_t want;
        @(posedge rst_n);
        forever
        begin
            stall_len = draw_wait();
            repeat (stall_len)
            begin
                @(negedge clk);
                rsp_stall <= 1'b1;
            end
            @(negedge clk);
            rsp_stall <= 1'b0;
            do
                @(posedge clk);
            while (rsp_valid !== 1'b1);
            got = {status, granted_index, is_assigned, used_count};
            if (awaited_results.size() == 0)
                flag_error($sformatf("result word with nothing awaited, status %0d",
                                     got.status));
            else
            begin
                want = awaited_results.pop_front();
                if (got.status !== want.status)
                    flag_error($sformatf("status got %0d expected %0d",
                                         got.status, want.status));
                if (got.granted !== want.granted)
                    flag_error($sformatf("granted_index got %0d expected %0d",
                                         got.granted, want.granted));
                if (got.assigned !== want.assigned)
                    flag_error($sformatf("is_assigned got %0d expected %0d",
                                         got.assigned, want.assigned));
                if (got.used !== want.used)
                    flag_error($sformatf("used_count got %0d expected %0d",
                                         got.used, want.used));
            end
        end
    end

    initial
    begin
        repeat (CYCLE_LIMIT)
            @(posedge clk);
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        load_phase_t phase;
        int roll;
        logic [1:0] m;
        logic [8:0] idx;
        clk            = 1'b0;
        rst_n          = 1'b0;
        req_valid      = 1'b0;
        mode           = MODE_ALLOC;
        entry_index    = '0;
        rsp_stall      = 1'b0;
        map_free       = '1;
        cursor         = CURSOR_RESET;
        taken_entries  = '0;
        errors         = 0;
        words_sent     = 0;
        grants         = 0;
        full_refusals  = 0;
        range_refusals = 0;
        calm           = 1'b0;
        repeat (6)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_word(directed_rows[i].req_mode, directed_rows[i].req_index,
                      directed_rows[i].fixed, directed_rows[i].want);
        hold_until_drained();

        // fill to beyond full, drain, mix, then fill again
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n < 400)
                phase = PH_FILL;
            else if (n < 700)
                phase = PH_DRAIN;
            else if (n < 900)
                phase = PH_MIX;
            else
                phase = PH_FILL;
            if (n == 400 || n == 700 || n == 900 || $urandom_range(0, 63) == 0)
                hold_until_drained();
            calm = ((n / 37) % 4 == 3);
            roll = $urandom_range(0, 99);
            idx = 9'($urandom_range(0, ENTRIES - 1));
            if (roll < 8)
            begin
                m = 2'($urandom_range(0, 3));
                idx = 9'($urandom);
            end
            else
            begin
                roll = $urandom_range(0, 99);
                case (phase)
                    PH_FILL:  m = roll < 80 ? MODE_ALLOC : (roll < 88 ? MODE_RELEASE : MODE_TEST);
                    PH_DRAIN: m = roll < 15 ? MODE_ALLOC : (roll < 85 ? MODE_RELEASE : MODE_TEST);
                    default:  m = roll < 40 ? MODE_ALLOC : (roll < 75 ? MODE_RELEASE : MODE_TEST);
                endcase
                if (m == MODE_RELEASE)
                    idx = pick_taken();
            end
            send_word(m, idx, 1'b0, '0);
        end
        calm = 1'b0;
        hold_until_drained();
        repeat (TAIL_CYCLES)
            @(posedge clk);

        $display("covered %0d request words: %0d grants, %0d refused with the map full,",
                 words_sent, grants, full_refusals);
        $display("%0d out of range or unused mode, %0d errors", range_refusals, errors);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
